/* rtl/core/bcc_pkg.sv */
// Shared constants, types and command/status structs for the binary row
// center and centroid block. No dependencies; every other file uses it.
package bcc_pkg;

   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;

   localparam int GRAY_W     = 8;
   localparam int CFG_SIZE_W = 11;
   localparam int OUT_W      = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam int COL_W   = $clog2(MAX_COLUMNS);
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int RSUM_W  = 2 * COL_W;
   localparam int FCNT_W  = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
   localparam int FCSUM_W = 2 * COL_W + ROW_W;
   localparam int FRSUM_W = COL_W + 2 * ROW_W;
   localparam int DIVD_W  = (FCSUM_W > FRSUM_W) ? FCSUM_W : FRSUM_W;
   localparam int DIVS_W  = FCNT_W;
   localparam int Q_W     = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int STEP_W  = $clog2(Q_W + 1);
   localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int SIZE_W  = (DIM_W > CFG_SIZE_W) ? DIM_W : CFG_SIZE_W;

   localparam logic [GRAY_W-1:0]     THRESHOLD_RESET = 8'd140;
   localparam logic [CFG_SIZE_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [CFG_SIZE_W-1:0] HEIGHT_RESET    = 11'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_THRESHOLD    = 2'd0,
      REG_FRAME_WIDTH  = 2'd1,
      REG_FRAME_HEIGHT = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      DIV_ROW_CENTER = 2'd0,
      DIV_FRAME_COL  = 2'd1,
      DIV_FRAME_ROW  = 2'd2
   } div_sel_type;

   typedef enum logic {
      KIND_ROW   = 1'b0,
      KIND_FRAME = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic            accept;
      logic            div_start;
      div_sel_type     div_sel;
      logic            keep_xq;
      logic            load_out;
      result_kind_type out_kind;
      logic            out_last;
      logic            clr_row;
      logic            clr_frame;
   } cmd_type;

   typedef struct packed {
      logic row_end;
      logic frame_end;
      logic row_has;
      logic frame_has;
      logic div_busy;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

/* rtl/core/bcc_if.sv */
// Channel interfaces: pixel input, result output and register writes.
// Depends on bcc_pkg for field widths.
interface bcc_req_if;
   logic                             valid;
   logic                             ready;
   logic [bcc_pkg::GRAY_W-1:0]       gray_level;
   logic                             start_of_frame;

   modport source (output valid, output gray_level, output start_of_frame, input ready);
   modport sink   (input valid, input gray_level, input start_of_frame, output ready);
endinterface

interface bcc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             result_kind;
   logic [bcc_pkg::OUT_W-1:0]        center_x;
   logic [bcc_pkg::OUT_W-1:0]        center_y;
   logic                             found;
   logic                             last;

   modport source (output valid, output result_kind, output center_x, output center_y,
                   output found, output last, input ready);
   modport sink   (input valid, input result_kind, input center_x, input center_y,
                   input found, input last, output ready);
endinterface

interface bcc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bcc_pkg::CSR_INDEX_W-1:0]  index;
   logic [bcc_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/bcc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all means.
// Depends on bcc_pkg for operand and quotient widths.
module bcc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bcc_pkg::DIVD_W-1:0]   dividend,
   input  logic [bcc_pkg::DIVS_W-1:0]   divisor,
   output logic                         busy,
   output logic                         done,
   output logic [bcc_pkg::Q_W-1:0]      quotient
);

   logic [bcc_pkg::DIVD_W-1:0] rem_ff, rem_in;
   logic [bcc_pkg::DIVD_W-1:0] dsh_ff, dsh_in;
   logic [bcc_pkg::DIVS_W-1:0] den_ff, den_in;
   logic [bcc_pkg::Q_W-1:0]    q_ff, q_in;
   logic [bcc_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       done_ff, done_in;

   // The quotient is a mean and always fits in Q_W bits, so the divisor
   // starts shifted up by Q_W-1 places and walks down one place a cycle.
   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dsh_in  = bcc_pkg::DIVD_W'(divisor) << (bcc_pkg::Q_W - 1);
         den_in  = divisor;
         q_in    = '0;
         step_in = bcc_pkg::STEP_W'(bcc_pkg::Q_W);
      end else if (step_ff != '0) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[bcc_pkg::Q_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[bcc_pkg::Q_W-2:0], 1'b0};
         end
         dsh_in  = dsh_ff >> 1;
         step_in = step_ff - bcc_pkg::STEP_W'(1);
         done_in = (step_ff == bcc_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy     = (step_ff != '0);
   assign done     = done_ff;
   assign quotient = q_ff;

   // When the quotient is ready, what is left must be below the divisor.
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < bcc_pkg::DIVD_W'(den_ff)))
      else $error("divider remainder not below divisor at completion");

endmodule

/* rtl/core/bcc_dp.sv */
// Datapath: configuration registers, pixel position, running sums,
// divider operand selection and the result register.
// Depends on bcc_pkg, bcc_if and bcc_div.
module bcc_dp (
   input  logic                 clock,
   input  logic                 reset,
   bcc_req_if.sink              req,
   bcc_rsp_if.source            rsp,
   bcc_csr_if.sink              csr,
   input  bcc_pkg::cmd_type     cmd,
   output bcc_pkg::status_type  st
);

   logic [bcc_pkg::GRAY_W-1:0]     thr_ff, thr_in;
   logic [bcc_pkg::CFG_SIZE_W-1:0] fw_ff, fw_in;
   logic [bcc_pkg::CFG_SIZE_W-1:0] fh_ff, fh_in;

   logic [bcc_pkg::COL_W-1:0]   col_ff, col_in;
   logic [bcc_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [bcc_pkg::ROW_W-1:0]   rowidx_ff, rowidx_in;
   logic [bcc_pkg::RSUM_W-1:0]  rsum_ff, rsum_in;
   logic [bcc_pkg::CNT_W-1:0]   rcnt_ff, rcnt_in;
   logic [bcc_pkg::FCSUM_W-1:0] fcsum_ff, fcsum_in;
   logic [bcc_pkg::FRSUM_W-1:0] frsum_ff, frsum_in;
   logic [bcc_pkg::FCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [bcc_pkg::Q_W-1:0]     xq_ff, xq_in;

   logic                        out_valid_ff, out_valid_in;
   logic                        kind_ff, kind_in;
   logic [bcc_pkg::OUT_W-1:0]   x_ff, x_in;
   logic [bcc_pkg::OUT_W-1:0]   y_ff, y_in;
   logic                        found_ff, found_in;
   logic                        last_ff, last_in;

   logic [bcc_pkg::SIZE_W-1:0]  w_eff, h_eff;
   logic [bcc_pkg::COL_W-1:0]   col_eff;
   logic [bcc_pkg::ROW_W-1:0]   row_eff;
   logic [bcc_pkg::RSUM_W-1:0]  rsum_eff;
   logic [bcc_pkg::CNT_W-1:0]   rcnt_eff;
   logic [bcc_pkg::FCSUM_W-1:0] fcsum_eff;
   logic [bcc_pkg::FRSUM_W-1:0] frsum_eff;
   logic [bcc_pkg::FCNT_W-1:0]  fcnt_eff;
   logic                        pix_set, row_end, frame_end, frame_has;

   logic [bcc_pkg::DIVD_W-1:0]  div_dividend;
   logic [bcc_pkg::DIVS_W-1:0]  div_divisor;
   logic                        div_busy, div_done;
   logic [bcc_pkg::Q_W-1:0]     div_q;

   assign csr.ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      fw_in  = fw_ff;
      fh_in  = fh_ff;
      if (csr.valid) begin
         case (bcc_pkg::reg_index_type'(csr.index))
            bcc_pkg::REG_THRESHOLD:    thr_in = csr.data[bcc_pkg::GRAY_W-1:0];
            bcc_pkg::REG_FRAME_WIDTH:  fw_in  = csr.data[bcc_pkg::CFG_SIZE_W-1:0];
            bcc_pkg::REG_FRAME_HEIGHT: fh_in  = csr.data[bcc_pkg::CFG_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // A size of zero acts as one; sizes above the maxima saturate.
   always_comb begin
      if (fw_ff == '0)
         w_eff = bcc_pkg::SIZE_W'(1);
      else if (bcc_pkg::SIZE_W'(fw_ff) > bcc_pkg::SIZE_W'(bcc_pkg::MAX_COLUMNS))
         w_eff = bcc_pkg::SIZE_W'(bcc_pkg::MAX_COLUMNS);
      else
         w_eff = bcc_pkg::SIZE_W'(fw_ff);
      if (fh_ff == '0)
         h_eff = bcc_pkg::SIZE_W'(1);
      else if (bcc_pkg::SIZE_W'(fh_ff) > bcc_pkg::SIZE_W'(bcc_pkg::MAX_ROWS))
         h_eff = bcc_pkg::SIZE_W'(bcc_pkg::MAX_ROWS);
      else
         h_eff = bcc_pkg::SIZE_W'(fh_ff);
   end

   // A start-of-frame pixel sees a cleared position and cleared sums.
   always_comb begin
      col_eff   = req.start_of_frame ? '0 : col_ff;
      row_eff   = req.start_of_frame ? '0 : row_ff;
      rsum_eff  = req.start_of_frame ? '0 : rsum_ff;
      rcnt_eff  = req.start_of_frame ? '0 : rcnt_ff;
      fcsum_eff = req.start_of_frame ? '0 : fcsum_ff;
      frsum_eff = req.start_of_frame ? '0 : frsum_ff;
      fcnt_eff  = req.start_of_frame ? '0 : fcnt_ff;
      pix_set   = (req.gray_level <= thr_ff);
      row_end   = ((bcc_pkg::SIZE_W'(col_eff) + bcc_pkg::SIZE_W'(1)) >= w_eff);
      frame_end = row_end &&
                  ((bcc_pkg::SIZE_W'(row_eff) + bcc_pkg::SIZE_W'(1)) >= h_eff);
      frame_has = (fcnt_ff != '0);
   end

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      rowidx_in = rowidx_ff;
      rsum_in   = rsum_ff;
      rcnt_in   = rcnt_ff;
      fcsum_in  = fcsum_ff;
      frsum_in  = frsum_ff;
      fcnt_in   = fcnt_ff;
      if (cmd.accept) begin
         rsum_in  = rsum_eff;
         rcnt_in  = rcnt_eff;
         fcsum_in = fcsum_eff;
         frsum_in = frsum_eff;
         fcnt_in  = fcnt_eff;
         if (pix_set) begin
            rsum_in  = rsum_eff + bcc_pkg::RSUM_W'(col_eff);
            rcnt_in  = rcnt_eff + bcc_pkg::CNT_W'(1);
            fcsum_in = fcsum_eff + bcc_pkg::FCSUM_W'(col_eff);
            frsum_in = frsum_eff + bcc_pkg::FRSUM_W'(row_eff);
            fcnt_in  = fcnt_eff + bcc_pkg::FCNT_W'(1);
         end
         rowidx_in = row_eff;
         if (row_end) begin
            col_in = '0;
            row_in = frame_end ? '0 : row_eff + bcc_pkg::ROW_W'(1);
         end else begin
            col_in = col_eff + bcc_pkg::COL_W'(1);
            row_in = row_eff;
         end
      end else begin
         // The row and frame sums stay until their results are in the result register.
         if (cmd.clr_row) begin
            rsum_in = '0;
            rcnt_in = '0;
         end
         if (cmd.clr_frame) begin
            fcsum_in = '0;
            frsum_in = '0;
            fcnt_in  = '0;
         end
      end
   end

   always_comb begin
      case (cmd.div_sel)
         bcc_pkg::DIV_FRAME_COL: begin
            div_dividend = bcc_pkg::DIVD_W'(fcsum_ff);
            div_divisor  = bcc_pkg::DIVS_W'(fcnt_ff);
         end
         bcc_pkg::DIV_FRAME_ROW: begin
            div_dividend = bcc_pkg::DIVD_W'(frsum_ff);
            div_divisor  = bcc_pkg::DIVS_W'(fcnt_ff);
         end
         default: begin
            div_dividend = bcc_pkg::DIVD_W'(rsum_ff);
            div_divisor  = bcc_pkg::DIVS_W'(rcnt_ff);
         end
      endcase
   end

   bcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      xq_in        = cmd.keep_xq ? div_q : xq_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         kind_in      = cmd.out_kind;
         last_in      = cmd.out_last;
         if (cmd.out_kind == bcc_pkg::KIND_FRAME) begin
            found_in = frame_has;
            x_in     = frame_has ? bcc_pkg::OUT_W'(xq_ff) : '0;
            y_in     = frame_has ? bcc_pkg::OUT_W'(div_q) : '0;
         end else begin
            found_in = 1'b0;
            x_in     = bcc_pkg::OUT_W'(div_q);
            y_in     = bcc_pkg::OUT_W'(rowidx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= bcc_pkg::THRESHOLD_RESET;
         fw_ff        <= bcc_pkg::WIDTH_RESET;
         fh_ff        <= bcc_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         rsum_ff      <= '0;
         rcnt_ff      <= '0;
         fcsum_ff     <= '0;
         frsum_ff     <= '0;
         fcnt_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rsum_ff      <= rsum_in;
         rcnt_ff      <= rcnt_in;
         fcsum_ff     <= fcsum_in;
         frsum_ff     <= frsum_in;
         fcnt_ff      <= fcnt_in;
         out_valid_ff <= out_valid_in;
      end
      rowidx_ff <= rowidx_in;
      xq_ff     <= xq_in;
      kind_ff   <= kind_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      found_ff  <= found_in;
      last_ff   <= last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = kind_ff;
   assign rsp.center_x    = x_ff;
   assign rsp.center_y    = y_ff;
   assign rsp.found       = found_ff;
   assign rsp.last        = last_ff;

   always_comb begin
      st.row_end   = row_end;
      st.frame_end = frame_end;
      st.row_has   = (rcnt_ff != '0);
      st.frame_has = frame_has;
      st.div_busy  = div_busy;
      st.div_done  = div_done;
      st.out_free  = !out_valid_ff || rsp.ready;
   end

   // Once a centroid is in the result register, the frame sums are gone.
   a_frame_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && cmd.out_kind == bcc_pkg::KIND_FRAME) |=> (fcnt_ff == '0))
      else $error("frame sums not cleared after centroid");

endmodule

/* rtl/core/bcc_ctrl.sv */
// Controller: accepts pixels, sequences the divisions at row and frame
// ends and loads the result register. Depends on bcc_pkg and bcc_if.
module bcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   bcc_req_if.sink              req,
   input  bcc_pkg::status_type  st,
   output bcc_pkg::cmd_type     cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_DIV_ROW,
      S_PUT_ROW,
      S_DIV_FCOL,
      S_DIV_FROW,
      S_PUT_FRAME
   } state_type;

   state_type state_ff, state_in;
   logic      frame_pend_ff, frame_pend_in;

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      frame_pend_in = frame_pend_ff;
      cmd           = '0;
      cmd.div_sel   = bcc_pkg::DIV_ROW_CENTER;
      cmd.out_kind  = bcc_pkg::KIND_ROW;
      case (state_ff)
         S_IDLE: begin
            cmd.accept = req.valid;
            if (req.valid && st.row_end) begin
               frame_pend_in = st.frame_end;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (st.row_has) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = bcc_pkg::DIV_ROW_CENTER;
               state_in      = S_DIV_ROW;
            end else if (frame_pend_ff) begin
               if (st.frame_has) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = bcc_pkg::DIV_FRAME_COL;
                  state_in      = S_DIV_FCOL;
               end else begin
                  state_in = S_PUT_FRAME;
               end
            end else begin
               cmd.clr_row = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DIV_ROW: begin
            if (st.div_done) state_in = S_PUT_ROW;
         end
         S_PUT_ROW: begin
            if (st.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_kind = bcc_pkg::KIND_ROW;
               cmd.out_last = !frame_pend_ff;
               if (frame_pend_ff) begin
                  // The row quotient is captured this cycle, so the divider
                  // can take the frame column sum at the same edge.
                  if (st.frame_has) begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = bcc_pkg::DIV_FRAME_COL;
                     state_in      = S_DIV_FCOL;
                  end else begin
                     state_in = S_PUT_FRAME;
                  end
               end else begin
                  cmd.clr_row = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         S_DIV_FCOL: begin
            cmd.div_sel = bcc_pkg::DIV_FRAME_ROW;
            if (st.div_done) begin
               cmd.keep_xq   = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = S_DIV_FROW;
            end
         end
         S_DIV_FROW: begin
            if (st.div_done) state_in = S_PUT_FRAME;
         end
         S_PUT_FRAME: begin
            if (st.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_kind  = bcc_pkg::KIND_FRAME;
               cmd.out_last  = 1'b1;
               cmd.clr_row   = 1'b1;
               cmd.clr_frame = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         frame_pend_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frame_pend_ff <= frame_pend_in;
      end
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> st.out_free)
      else $error("result register loaded while still occupied");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !st.div_busy)
      else $error("divider started while busy");

   a_no_pixel_in_division: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> !st.div_busy)
      else $error("pixel transfer taken during a division");

endmodule

/* rtl/core/binary_row_centers_and_centroid.sv */
// Binary row centers and frame centroid: top level. Pixels are thresholded
// (set at or below the threshold) and summed as they stream in; plain
// pixels that do not close a row flow at one per clock. A pixel that
// closes a row holds the input while the controller checks for set pixels,
// runs the divisions and loads the results, plus any wait for the result
// register to drain. Division uses the single shared restoring divider,
// which produces one quotient bit per cycle (10 bits here) for each of up
// to three means. Result items wait in an output register, so a pending
// result does not stop pixel transfers once the divisions are done. Depends
// on bcc_pkg, bcc_if, bcc_ctrl and bcc_dp.
module binary_row_centers_and_centroid (
   input  logic        clock,
   input  logic        reset,
   bcc_req_if.sink     req_ch,
   bcc_rsp_if.source   rsp_ch,
   bcc_csr_if.sink     csr_ch
);

   bcc_pkg::cmd_type    cmd;
   bcc_pkg::status_type st;

   bcc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .st    (st),
      .cmd   (cmd)
   );

   bcc_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch),
      .cmd   (cmd),
      .st    (st)
   );

endmodule

/* tb/tb_binary_row_centers_and_centroid.sv */
// Self-checking testbench for binary_row_centers_and_centroid: streams pixel
// frames under changing register settings, predicts row centers and frame
// centroids, and checks every result. Depends on bcc_pkg, bcc_if and the RTL.
module tb_binary_row_centers_and_centroid;
   timeunit 1ns;
   timeprecision 1ps;
   import bcc_pkg::*;

   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PIXEL_TARGET  = 1850;

   // Kinds of random pixel sequences; anything else is a well-formed frame.
   localparam int SEQ_NOISE     = 0;
   localparam int SEQ_TRUNCATED = 1;
   localparam int SEQ_NO_START  = 2;

   typedef struct {
      logic [GRAY_W-1:0] gray;
      logic              sof;
   } pixel_type;

   typedef struct {
      result_kind_type  kind;
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
      logic             found;
      logic             last;
   } center_type;

   logic clock = 1'b0;
   logic reset;

   bcc_req_if req_ch();
   bcc_rsp_if rsp_ch();
   bcc_csr_if csr_ch();

   binary_row_centers_and_centroid u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pixel_type  pending_pixels[$];
   center_type expected_centers[$];

   // Predicted register settings and accumulation state.
   logic [GRAY_W-1:0]     thr_cfg    = THRESHOLD_RESET;
   logic [CFG_SIZE_W-1:0] width_cfg  = WIDTH_RESET;
   logic [CFG_SIZE_W-1:0] height_cfg = HEIGHT_RESET;
   int unsigned           col_pos    = 0;
   int unsigned           row_pos    = 0;
   longint unsigned       row_col_sum   = 0;
   longint unsigned       row_count     = 0;
   longint unsigned       frame_col_sum = 0;
   longint unsigned       frame_row_sum = 0;
   longint unsigned       frame_count   = 0;

   int   failures         = 0;
   int   quiet_cycles     = 0;
   int   pixels_queued    = 0;
   int   pixels_offered   = 0;
   int   pixels_predicted = 0;
   int   send_idle_pct    = 0;
   int   recv_idle_pct    = 0;
   int   hold_left        = 0;
   int   hold_requests    = 0;
   int   holds_started    = 0;
   logic pixel_taken      = 1'b0;

   always #6 clock = ~clock;

   function automatic int unsigned clamp_dim(logic [CFG_SIZE_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic void predict_centers(logic [GRAY_W-1:0] gray, logic sof);
      int unsigned w;
      int unsigned h;
      center_type  made[2];
      int          n;
      w = clamp_dim(width_cfg, MAX_COLUMNS);
      h = clamp_dim(height_cfg, MAX_ROWS);
      n = 0;
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
         row_col_sum = 0;
         row_count = 0;
         frame_col_sum = 0;
         frame_row_sum = 0;
         frame_count = 0;
      end
      if (gray <= thr_cfg) begin
         row_col_sum += col_pos;
         row_count += 1;
         frame_col_sum += col_pos;
         frame_row_sum += row_pos;
         frame_count += 1;
      end
      if (col_pos + 1 >= w) begin
         if (row_count != 0) begin
            made[n].kind  = KIND_ROW;
            made[n].x     = OUT_W'(row_col_sum / row_count);
            made[n].y     = OUT_W'(row_pos);
            made[n].found = 1'b0;
            n++;
         end
         row_col_sum = 0;
         row_count = 0;
         col_pos = 0;
         if (row_pos + 1 >= h) begin
            made[n].kind = KIND_FRAME;
            if (frame_count != 0) begin
               made[n].x     = OUT_W'(frame_col_sum / frame_count);
               made[n].y     = OUT_W'(frame_row_sum / frame_count);
               made[n].found = 1'b1;
            end else begin
               made[n].x     = '0;
               made[n].y     = '0;
               made[n].found = 1'b0;
            end
            n++;
            frame_col_sum = 0;
            frame_row_sum = 0;
            frame_count = 0;
            row_pos = 0;
         end else begin
            row_pos++;
         end
      end else begin
         col_pos++;
      end
      for (int i = 0; i < n; i++) begin
         made[i].last = (i == n - 1);
         expected_centers = {expected_centers, made[i]};
      end
   endfunction

   function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                       logic [OUT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // A pixel once offered is never withdrawn, so it is predicted at the first
   // edge it is presented.
   always @(posedge clock) begin : result_monitor
      logic       rsp_fire;
      center_type want;
      if (!reset && req_ch.valid && pixels_predicted != pixels_offered) begin
         predict_centers(req_ch.gray_level, req_ch.start_of_frame);
         pixels_predicted = pixels_offered;
      end
      pixel_taken = !reset && req_ch.valid && req_ch.ready;
      rsp_fire = !reset && rsp_ch.valid && rsp_ch.ready;
      if (rsp_fire) begin
         if (expected_centers.size() == 0) begin
            $error("unexpected result: kind %0d x %0d y %0d found %0d last %0d",
                   rsp_ch.result_kind, rsp_ch.center_x, rsp_ch.center_y,
                   rsp_ch.found, rsp_ch.last);
            failures++;
         end else begin
            want = expected_centers.pop_front();
            check_field("result_kind", want.kind, rsp_ch.result_kind);
            check_field("center_x", want.x, rsp_ch.center_x);
            check_field("center_y", want.y, rsp_ch.center_y);
            check_field("found", want.found, rsp_ch.found);
            check_field("last", want.last, rsp_ch.last);
         end
      end
      if (pixel_taken || rsp_fire || (!reset && csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : pixel_driver
      pixel_type px;
      if (reset) begin
         req_ch.valid          <= 1'b0;
         req_ch.gray_level     <= '0;
         req_ch.start_of_frame <= 1'b0;
      end else if (!req_ch.valid || pixel_taken) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            px = pending_pixels.pop_front();
            req_ch.valid          <= 1'b1;
            req_ch.gray_level     <= px.gray;
            req_ch.start_of_frame <= px.sof;
            pixels_offered++;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : result_receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (holds_started != hold_requests) begin
         holds_started++;
         hold_left = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic queue_pixel(logic [GRAY_W-1:0] gray, logic sof);
      pixel_type px;
      px.gray = gray;
      px.sof  = sof;
      pending_pixels = {pending_pixels, px};
      pixels_queued++;
   endtask

   function automatic logic [GRAY_W-1:0] pick_gray(int set_pct);
      if ($urandom_range(7) == 0) return GRAY_W'($urandom_range(255));
      if ($urandom_range(99) < set_pct || thr_cfg == 8'hFF)
         return GRAY_W'($urandom_range(thr_cfg));
      return GRAY_W'($urandom_range(255, thr_cfg + 1));
   endfunction

   task automatic queue_pixels(int count, logic first_sof, int set_pct);
      for (int i = 0; i < count; i++) queue_pixel(pick_gray(set_pct), first_sof && i == 0);
   endtask

   // Registers change only with the block idle: all pixels taken, all results
   // back, and a margin for a division that produced nothing.
   task automatic drain_results();
      while (pending_pixels.size() != 0 || req_ch.valid || expected_centers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         REG_THRESHOLD:    thr_cfg = value[GRAY_W-1:0];
         REG_FRAME_WIDTH:  width_cfg = value;
         REG_FRAME_HEIGHT: height_cfg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic random_segment();
      reg_index_type         idx;
      logic [CSR_DATA_W-1:0] value;
      int                    size;
      int                    set_pct;
      drain_results();
      repeat ($urandom_range(3, 1)) begin
         idx = reg_index_type'($urandom_range(2));
         value = CSR_DATA_W'($urandom_range(2047));
         case (idx)
            REG_THRESHOLD: begin
               if ($urandom_range(3) == 0) value[GRAY_W-1:0] = $urandom_range(1) ? 8'hFF : 8'h00;
            end
            REG_FRAME_WIDTH: begin
               value = CSR_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(15)
                                                            : $urandom_range(40, 16));
            end
            default: begin
               value = CSR_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(8, 0)
                                                            : $urandom_range(4, 1));
            end
         endcase
         write_reg(idx, value);
      end
      repeat ($urandom_range(3, 1)) begin
         size = clamp_dim(width_cfg, MAX_COLUMNS) * clamp_dim(height_cfg, MAX_ROWS);
         set_pct = ($urandom_range(4) == 0) ? 0 : $urandom_range(60, 5);
         case ($urandom_range(9))
            SEQ_NOISE:
               repeat ($urandom_range(20, 1))
                  queue_pixel(GRAY_W'($urandom_range(255)), $urandom_range(5) == 0);
            SEQ_TRUNCATED: queue_pixels((size > 1) ? $urandom_range(size - 1, 1) : 1, 1'b1,
                                        set_pct);
            SEQ_NO_START:  queue_pixels(size, 1'b0, set_pct);
            default:       queue_pixels(size, 1'b1, set_pct);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_THRESHOLD;
      csr_ch.data = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 36;
      recv_idle_pct = 48;

      // Reset settings: the threshold is inclusive at 140.
      queue_pixel(8'd140, 1'b1);
      queue_pixel(8'd141, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0);
      drain_results();
      // Width of zero acts as one, so the row ends at the next pixel.
      write_reg(REG_FRAME_WIDTH, 11'd0);
      queue_pixel(8'd140, 1'b0);
      drain_results();
      write_reg(REG_FRAME_HEIGHT, 11'd0);
      queue_pixel(8'd140, 1'b0);
      drain_results();
      // Threshold extremes; a pixel above threshold gives an empty frame.
      write_reg(REG_THRESHOLD, 11'h000);
      queue_pixel(8'd0, 1'b1);
      queue_pixel(8'd1, 1'b0);
      drain_results();
      write_reg(REG_THRESHOLD, 11'h7FF);
      queue_pixel(8'd255, 1'b0);
      drain_results();
      // Saturated sizes, a start mark mid-frame, then sizes cut mid-frame.
      write_reg(REG_THRESHOLD, 11'd128);
      write_reg(REG_FRAME_WIDTH, 11'h7FF);
      write_reg(REG_FRAME_HEIGHT, 11'h7FF);
      queue_pixel(8'd127, 1'b1);
      queue_pixel(8'd128, 1'b0);
      queue_pixel(8'd129, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd128, 1'b1);
      queue_pixel(8'd50, 1'b0);
      queue_pixel(8'd129, 1'b0);
      drain_results();
      write_reg(REG_FRAME_WIDTH, 11'd0);
      queue_pixel(8'd128, 1'b0);
      queue_pixel(8'd0, 1'b0);
      queue_pixel(8'd255, 1'b0);
      queue_pixel(8'd128, 1'b0);
      drain_results();
      write_reg(REG_FRAME_HEIGHT, 11'd1);
      queue_pixel(8'd0, 1'b0);
      // No start mark after a frame end: each pixel begins a new frame.
      queue_pixel(8'd200, 1'b0);
      queue_pixel(8'd100, 1'b0);

      while (pixels_queued < 300) random_segment();

      // Tall single-column frame while the receiver holds off for a long stretch,
      // so the output register fills and the pixel input stalls.
      drain_results();
      write_reg(REG_THRESHOLD, 11'd128);
      write_reg(REG_FRAME_WIDTH, 11'd1);
      write_reg(REG_FRAME_HEIGHT, 11'd520);
      queue_pixels(520, 1'b1, 50);
      hold_requests++;

      while (pixels_queued < 1200) random_segment();

      send_idle_pct = 48;
      recv_idle_pct = 36;
      drain_results();
      // One wide row with set pixels denser in the upper columns.
      write_reg(REG_THRESHOLD, 11'd100);
      write_reg(REG_FRAME_WIDTH, 11'd600);
      write_reg(REG_FRAME_HEIGHT, 11'd1);
      for (int c = 0; c < 600; c++)
         queue_pixel((c == 599) ? 8'd0 : pick_gray((c >= 520) ? 30 : 2), c == 0);

      while (pixels_queued < 1500) random_segment();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (pixels_queued < PIXEL_TARGET) random_segment();

      drain_results();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
